/* design/pav_pkg.sv */
// ----------------------------------------------------------------------------
// pav_pkg
// Shared types and codes of the pool-adjacent-violators block.
// ----------------------------------------------------------------------------
`default_nettype none

package pav_pkg;

  localparam int unsigned TOL_W     = 21;
  localparam int unsigned TOL_FRAC  = 20;
  localparam int unsigned Q16_FRAC  = 16;
  localparam int unsigned MEAN_W    = 48;
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned TOTAL_W   = 11;

  localparam logic [TOL_W-1:0] TOL_RESET = 21'd1048575;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_PUSH   = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SAMPLE_W-1:0] sample_value;
    logic [INDEX_W-1:0]  block_index;
  } pav_in_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] block_total;
    logic [TOTAL_W-1:0] block_points;
    logic [MEAN_W-1:0]  block_mean_q16;
    logic [1:0]         status;
  } pav_out_t;

endpackage

`default_nettype wire

/* design/pav_mem.sv */
// ----------------------------------------------------------------------------
// pav_mem
// Block store: one synchronous port each for write and read, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pav_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 53
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/pav_cmp.sv */
// ----------------------------------------------------------------------------
// pav_cmp
// Serial merge test: sum_top*cnt_low*2^20 >= sum_low*cnt_top*tol.
// ----------------------------------------------------------------------------
`default_nettype none

module pav_cmp #(
  parameter int unsigned SUM_W = 42,
  parameter int unsigned CNT_W = 11
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [SUM_W-1:0]          sum_top_i,
  input  logic [CNT_W-1:0]          cnt_top_i,
  input  logic [SUM_W-1:0]          sum_low_i,
  input  logic [CNT_W-1:0]          cnt_low_i,
  input  logic [pav_pkg::TOL_W-1:0] tol_i,
  output logic                      done_o,
  output logic                      merge_o
);
  import pav_pkg::*;

  localparam int unsigned P_W    = SUM_W + CNT_W;
  localparam int unsigned X_W    = P_W + TOL_W;
  localparam int unsigned STEPS  = (CNT_W > TOL_W) ? CNT_W : TOL_W;
  localparam int unsigned STEP_W = $clog2(STEPS + 1);

  logic              busy_q, phase_q, done_q, merge_q;
  logic [STEP_W-1:0] step_q;
  logic [P_W-1:0]    a1_q, a2_q, p1_q, p2_q;
  logic [CNT_W-1:0]  b1_q, b2_q;
  logic [X_W-1:0]    a3_q, p3_q;
  logic [TOL_W-1:0]  b3_q;

  logic [P_W-1:0] p1_add, p2_add;
  logic [X_W-1:0] p3_add, lhs;

  assign p1_add = p1_q + (b1_q[0] ? a1_q : '0);
  assign p2_add = p2_q + (b2_q[0] ? a2_q : '0);
  assign p3_add = p3_q + (b3_q[0] ? a3_q : '0);
  assign lhs    = X_W'(p1_q) << TOL_FRAC;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        step_q  <= '0;
      end else if (busy_q) begin
        if (!phase_q) begin
          if (step_q == STEP_W'(CNT_W - 1)) begin
            phase_q <= 1'b1;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end else begin
          if (step_q == STEP_W'(TOL_W - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
      end
    end
  end

  // operand and partial-product registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a1_q <= P_W'(sum_top_i);
      b1_q <= cnt_low_i;
      a2_q <= P_W'(sum_low_i);
      b2_q <= cnt_top_i;
      p1_q <= '0;
      p2_q <= '0;
      b3_q <= tol_i;
    end else if (busy_q && !phase_q) begin
      p1_q <= p1_add;
      p2_q <= p2_add;
      a1_q <= a1_q << 1;
      a2_q <= a2_q << 1;
      b1_q <= b1_q >> 1;
      b2_q <= b2_q >> 1;
      a3_q <= X_W'(p2_add);
      p3_q <= '0;
    end else if (busy_q) begin
      p3_q    <= p3_add;
      a3_q    <= a3_q << 1;
      b3_q    <= b3_q >> 1;
      merge_q <= (lhs >= p3_add);
    end
  end

  assign done_o  = done_q;
  assign merge_o = merge_q;

endmodule

`default_nettype wire

/* design/pav_div.sv */
// ----------------------------------------------------------------------------
// pav_div
// Restoring divider, one quotient bit a cycle: floor(sum*2^16/cnt).
// ----------------------------------------------------------------------------
`default_nettype none

module pav_div #(
  parameter int unsigned SUM_W = 42,
  parameter int unsigned CNT_W = 11
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [SUM_W-1:0]           sum_i,
  input  logic [CNT_W-1:0]           cnt_i,
  output logic                       done_o,
  output logic [pav_pkg::MEAN_W-1:0] mean_o
);
  import pav_pkg::*;

  localparam int unsigned DVD_W  = SUM_W + Q16_FRAC;
  localparam int unsigned STEP_W = $clog2(DVD_W + 1);

  logic              busy_q, done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  dvd_q, q_q;
  logic [CNT_W-1:0]  rem_q, div_q;

  logic [CNT_W:0]   rem_sh, diff;
  logic             ge;
  logic [CNT_W-1:0] rem_next;

  assign rem_sh   = {rem_q, dvd_q[DVD_W-1]};
  assign diff     = rem_sh - {1'b0, div_q};
  assign ge       = (rem_sh >= {1'b0, div_q});
  assign rem_next = ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == STEP_W'(DVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {sum_i, {Q16_FRAC{1'b0}}};
      rem_q <= '0;
      div_q <= cnt_i;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_next;
      q_q   <= {q_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign mean_o = MEAN_W'(q_q);

endmodule

`default_nettype wire

/* design/pool_adjacent_violators.sv */
// ----------------------------------------------------------------------------
// pool_adjacent_violators: isotonic (non-increasing) fit by pooling blocks.
// Push: each merge test runs on a serial multiplier (pav_cmp).
// Read: the block mean comes from a bit-serial divider (pav_div).
// Reset clears stack top and point count at once; the store needs no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_adjacent_violators #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [pav_pkg::TOL_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  pav_pkg::pav_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pav_pkg::pav_out_t         out_data_o
);
  import pav_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned SUM_W = VALUE_BITS + CNT_W;
  localparam int unsigned ENT_W = SUM_W + CNT_W;
  localparam int unsigned CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
  localparam logic [SAMPLE_W-1:0] VAL_MASK = (VALUE_BITS >= SAMPLE_W) ? '1 :
      SAMPLE_W'((64'd1 << VALUE_BITS) - 64'd1);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_RDREQ  = 7'b0000010,
    S_RDWAIT = 7'b0000100,
    S_CMP    = 7'b0001000,
    S_DIV    = 7'b0010000,
    S_WR     = 7'b0100000,
    S_RESP   = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // The top block of the stack lives in cur_sum/cur_cnt while a push runs;
  // the store holds only the blocks below it. t_q is the top block's slot.
  logic [TOL_W-1:0]  tol_q;
  logic [CNT_W-1:0]  top_q, top_d, pushed_q, pushed_d, t_q, t_d;
  logic [SUM_W-1:0]  cur_sum_q, cur_sum_d;
  logic [CNT_W-1:0]  cur_cnt_q, cur_cnt_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic              is_read_q, is_read_d;
  logic [TOTAL_W-1:0] pts_q, pts_d;
  logic [MEAN_W-1:0] mean_q, mean_d;
  logic [1:0]        status_q, status_d;
  logic              out_valid_q;
  pav_out_t          out_q;
  logic              out_load;

  logic              mem_we, mem_re;
  logic [ENT_W-1:0]  mem_rdata;
  logic [SUM_W-1:0]  rd_sum;
  logic [CNT_W-1:0]  rd_cnt;

  logic              cmp_start, cmp_done, cmp_merge;
  logic              div_start, div_done;
  logic [MEAN_W-1:0] div_mean;

  assign rd_sum = mem_rdata[ENT_W-1:CNT_W];
  assign rd_cnt = mem_rdata[CNT_W-1:0];

  pav_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW),
    .DW    (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(t_q)),
    .wdata_i ({cur_sum_q, cur_cnt_q}),
    .re_i    (mem_re),
    .raddr_i (addr_q),
    .rdata_o (mem_rdata)
  );

  pav_cmp #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmp_start),
    .sum_top_i (cur_sum_q),
    .cnt_top_i (cur_cnt_q),
    .sum_low_i (rd_sum),
    .cnt_low_i (rd_cnt),
    .tol_i     (tol_q),
    .done_o    (cmp_done),
    .merge_o   (cmp_merge)
  );

  pav_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (rd_sum),
    .cnt_i   (rd_cnt),
    .done_o  (div_done),
    .mean_o  (div_mean)
  );

  // Sequencer. Every store access is issued from its own state, so a read
  // never meets a write to the same entry in one cycle: no forwarding needed.
  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    pushed_d  = pushed_q;
    t_d       = t_q;
    cur_sum_d = cur_sum_q;
    cur_cnt_d = cur_cnt_q;
    addr_d    = addr_q;
    is_read_d = is_read_q;
    pts_d     = pts_q;
    mean_d    = mean_q;
    status_d  = status_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    cmp_start = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          is_read_d = 1'b0;
          pts_d     = '0;
          mean_d    = '0;
          status_d  = ST_OK;
          state_d   = S_RESP;
          case (in_data_i.req_type)
            REQ_CLEAR: begin
              top_d    = '0;
              pushed_d = '0;
            end
            REQ_PUSH: begin
              if (pushed_q >= CNT_W'(MAX_POINTS) || top_q >= CNT_W'(MAX_POINTS)) begin
                status_d = ST_FULL;
              end else begin
                pushed_d  = pushed_q + 1'b1;
                cur_sum_d = SUM_W'(in_data_i.sample_value & VAL_MASK);
                cur_cnt_d = CNT_W'(1);
                t_d       = top_q;
                addr_d    = AW'(top_q - 1'b1);
                state_d   = (top_q == '0) ? S_WR : S_RDREQ;
              end
            end
            REQ_READ: begin
              if (CMP_W'(in_data_i.block_index) < CMP_W'(top_q)) begin
                is_read_d = 1'b1;
                addr_d    = AW'(in_data_i.block_index);
                state_d   = S_RDREQ;
              end else begin
                status_d = ST_RANGE;
              end
            end
            default: begin
              // unused request: report current count only
            end
          endcase
        end
      end
      S_RDREQ: begin
        mem_re  = 1'b1;
        state_d = S_RDWAIT;
      end
      S_RDWAIT: begin
        if (is_read_q) begin
          div_start = 1'b1;
          pts_d     = TOTAL_W'(rd_cnt);
          state_d   = S_DIV;
        end else begin
          cmp_start = 1'b1;
          state_d   = S_CMP;
        end
      end
      S_CMP: begin
        if (cmp_done) begin
          if (cmp_merge) begin
            // fold the top block into the one below and test again while one remains below
            cur_sum_d = cur_sum_q + rd_sum;
            cur_cnt_d = cur_cnt_q + rd_cnt;
            t_d       = t_q - 1'b1;
            addr_d    = AW'(t_q - CNT_W'(2));
            state_d   = (t_q == CNT_W'(1)) ? S_WR : S_RDREQ;
          end else begin
            state_d = S_WR;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mean_d  = div_mean;
          state_d = S_RESP;
        end
      end
      S_WR: begin
        mem_we  = 1'b1;
        top_d   = t_q + 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tol_q       <= TOL_RESET;
      top_q       <= '0;
      pushed_q    <= '0;
      is_read_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      top_q     <= top_d;
      pushed_q  <= pushed_d;
      is_read_q <= is_read_d;
      if (cfg_we_i) begin
        tol_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    t_q       <= t_d;
    cur_sum_q <= cur_sum_d;
    cur_cnt_q <= cur_cnt_d;
    addr_q    <= addr_d;
    pts_q     <= pts_d;
    mean_q    <= mean_d;
    status_q  <= status_d;
    if (out_load) begin
      out_q.block_total    <= TOTAL_W'(top_q);
      out_q.block_points   <= pts_q;
      out_q.block_mean_q16 <= mean_q;
      out_q.status         <= status_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // The stack can never hold more blocks than points pushed.
  assert property (@(posedge clk_i) disable iff (!rst_ni) top_q <= pushed_q)
    else $error("stack top exceeds pushed points");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      mem_we |-> (t_q < CNT_W'(MAX_POINTS)))
    else $error("block write beyond capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      cmp_done |-> (state_q == S_CMP))
    else $error("merge test finished outside compare");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      div_done |-> (state_q == S_DIV))
    else $error("divide finished outside read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result loaded outside response");

endmodule

`default_nettype wire

/* sim/pool_adjacent_violators_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pool_adjacent_violators_tb
// Drives clear, push, read and unused requests into the pooling block under several
// merge tolerances, predicts every response with an exact software copy of
// the pooled-block stack and compares each response field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module pool_adjacent_violators_tb;
  import pav_pkg::*;

  localparam int unsigned MAX_PTS = 1024;

  // Software copy of the pooled-block stack; computes the expected responses
  // and checks the block's responses against them in order.
  class pav_scoreboard;
    logic [63:0]        sums [MAX_PTS];
    int unsigned        cnts [MAX_PTS];
    int unsigned        top;
    int unsigned        pushed;
    logic [TOL_W-1:0]   tol;
    pav_out_t           pending[$];
    int unsigned        errors;

    function void clear_all();
      top = 0;
      pushed = 0;
      tol = TOL_RESET;
      errors = 0;
      pending.delete();
    endfunction

    // Merge when sum_t*cnt_l*2^20 >= sum_l*cnt_t*tol, exact.
    function bit must_merge(int unsigned t);
      logic [127:0] lhs;
      logic [127:0] rhs;
      lhs = (128'(sums[t]) * 128'(cnts[t-1])) << TOL_FRAC;
      rhs = 128'(sums[t-1]) * 128'(cnts[t]) * 128'(tol);
      return lhs >= rhs;
    endfunction

    function void note_request(pav_in_t req);
      pav_out_t     res;
      int unsigned  t;
      logic [127:0] q;
      res = '0;
      case (req.req_type)
        REQ_CLEAR: begin
          top = 0;
          pushed = 0;
        end
        REQ_PUSH: begin
          if (pushed >= MAX_PTS || top >= MAX_PTS) begin
            res.status = ST_FULL;
          end else begin
            t = top;
            sums[t] = 64'(req.sample_value);
            cnts[t] = 1;
            pushed++;
            while (t > 0 && must_merge(t)) begin
              sums[t-1] += sums[t];
              cnts[t-1] += cnts[t];
              t--;
            end
            top = t + 1;
          end
        end
        REQ_READ: begin
          if (req.block_index >= top) begin
            res.status = ST_RANGE;
          end else begin
            res.block_points = TOTAL_W'(cnts[req.block_index]);
            q = (128'(sums[req.block_index]) << Q16_FRAC) / 128'(cnts[req.block_index]);
            res.block_mean_q16 = q[MEAN_W-1:0];
          end
        end
        default: ;
      endcase
      res.block_total = TOTAL_W'(top);
      pending = {pending, res};
    endfunction

    function void check_response(pav_out_t got);
      pav_out_t exp;
      if (pending.size() == 0) begin
        $error("response with nothing pending: %p", got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.block_total !== exp.block_total) begin
        $error("block_total exp %0d got %0d", exp.block_total, got.block_total);
        errors++;
      end
      if (got.block_points !== exp.block_points) begin
        $error("block_points exp %0d got %0d", exp.block_points, got.block_points);
        errors++;
      end
      if (got.block_mean_q16 !== exp.block_mean_q16) begin
        $error("block_mean_q16 exp %0d got %0d", exp.block_mean_q16, got.block_mean_q16);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TOL_W-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  pav_in_t          in_data_i;
  logic             out_valid_o;
  logic             out_stall_i;
  pav_out_t         out_data_o;

  pav_scoreboard stack_model;

  pool_adjacent_violators DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop; the slowest run (bit-serial reads plus stalls) stays far
  // below this.
  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: draw a stall length per response, then sample on the rising edge.
  initial begin : response_side
    int unsigned hold;
    out_stall_i = 1'b1;
    wait (rst_ni === 1'b1);
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      repeat (hold) @(negedge clk_i);
      @(negedge clk_i);
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      stack_model.check_response(out_data_o);
      @(negedge clk_i);
      out_stall_i = 1'b1;
    end
  end

  // Send one request; hold it until the transfer, after a random gap.
  task automatic send_request(logic [1:0] kind, logic [31:0] value, logic [9:0] idx);
    int unsigned gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
    repeat (gap) @(negedge clk_i);
    in_data_i.req_type     = kind;
    in_data_i.sample_value = value;
    in_data_i.block_index  = idx;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    stack_model.note_request(in_data_i);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Wait for all responses, then let any trailing work settle.
  task automatic drain();
    while (stack_model.pending.size() != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // Write the tolerance while idle.
  task automatic set_tolerance(logic [TOL_W-1:0] tol);
    drain();
    cfg_wdata_i = tol;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    stack_model.tol = tol;
  endtask

  // Read random blocks, now and then one out of range.
  task automatic read_some(int unsigned n);
    int unsigned top;
    repeat (n) begin
      top = stack_model.top;
      if (top == 0 || $urandom_range(0, 7) == 0)
        send_request(REQ_READ, $urandom, 10'($urandom));
      else
        send_request(REQ_READ, $urandom, 10'($urandom_range(0, top - 1)));
    end
  endtask

  // A mostly well-formed session: clear, pushes with a bias toward
  // decreasing runs and violators, interleaved reads.
  task automatic random_session(int unsigned n);
    logic [31:0] v;
    logic [31:0] last;
    send_request(REQ_CLEAR, $urandom, 10'($urandom));
    last = $urandom;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = $urandom;
        3, 4: v = last - $urandom_range(0, 50);
        5: v = last + $urandom_range(0, 50);
        6: v = (32'($urandom_range(0, 1)) << 31) | ($urandom & 32'hff);
        default: v = $urandom_range(0, 1000);
      endcase
      last = v;
      case ($urandom_range(0, 19))
        0: send_request(REQ_UNUSED, $urandom, 10'($urandom));
        1, 2, 3, 4: read_some(1);
        5: send_request(REQ_CLEAR, $urandom, 10'($urandom));
        default: send_request(REQ_PUSH, v, 10'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    logic [TOL_W-1:0] tols[5];
    stack_model = new();
    stack_model.clear_all();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, unused request type, out-of-range read, clear.
    send_request(REQ_READ, 32'd0, 10'd0);
    send_request(REQ_PUSH, 32'hffff_ffff, 10'h3ff);
    send_request(REQ_PUSH, 32'hffff_ffff, 10'd0);
    send_request(REQ_PUSH, 32'd0, 10'd0);
    send_request(REQ_PUSH, 32'd7, 10'd0);
    send_request(REQ_PUSH, 32'd3, 10'd0);
    send_request(REQ_READ, 32'd0, 10'd0);
    send_request(REQ_READ, 32'd0, 10'd1);
    send_request(REQ_READ, 32'd0, 10'h3ff);
    send_request(REQ_UNUSED, 32'hffff_ffff, 10'h3ff);
    send_request(REQ_CLEAR, 32'hffff_ffff, 10'h3ff);
    send_request(REQ_READ, 32'd0, 10'd0);

    // Hold off until every response is back.
    drain();

    // Build a deep stack with strictly decreasing values so no merge
    // happens, then read its top and bottom.
    set_tolerance(21'd1048576);
    for (int i = 0; i < 100; i++)
      send_request(REQ_PUSH, 32'(2000 - i), 10'($urandom));
    send_request(REQ_READ, 32'd0, 10'd99);
    send_request(REQ_READ, 32'd0, 10'd0);
    send_request(REQ_CLEAR, 32'd0, 10'd0);

    // Tolerance 0 pools everything into one block.
    set_tolerance(21'd0);
    random_session(30);
    read_some(4);

    tols[0] = TOL_RESET;
    tols[1] = 21'h1f_ffff;
    tols[2] = 21'd524288;
    tols[3] = 21'd1048576;
    tols[4] = 21'($urandom);
    foreach (tols[k]) begin
      set_tolerance(tols[k]);
      random_session(99);
    end

    drain();
    if (stack_model.errors == 0 && stack_model.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
design/pav_pkg.sv
design/pav_mem.sv
design/pav_cmp.sv
design/pav_div.sv
design/pool_adjacent_violators.sv
sim/pool_adjacent_violators_tb.sv
